// ===== rtl/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Types and constants shared by the stepper axis step generator.
// ----------------------------------------------------------------------------
package stp_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam logic [DATA_W-1:0] HOME_RESET = 32'd1000;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic       move_dir;
      logic       limit_left;
      logic       limit_right;
      logic       reference_level;
   } req_type;

   typedef struct packed {
      logic              step_out;
      logic              moving;
      logic [DATA_W-1:0] position;
      logic [DATA_W-1:0] total_length;
      logic [DATA_W-1:0] ref_start;
      logic [DATA_W-1:0] ref_end;
      logic [DATA_W-1:0] ref_length;
      logic              ref_ok;
   } rsp_type;

endpackage

// ===== rtl/stepper_axis_pulse_and_measure_top.sv =====
// ----------------------------------------------------------------------------
// stepper_axis_pulse_and_measure_top
// Stepper axis step generator with limit stops and reference measurement.
// ----------------------------------------------------------------------------
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    stp_pkg::req_type
//   rsp      out        rsp_valid/stall    stp_pkg::rsp_type
//   csr      in         csr_valid/ready    home position, 32 bits
//
// One transaction per cycle unless rsp stalls; the path runs input register
// to result register, with the axis update done in the logic between them.
// Reset clears the axis state and loads the home position with 1000.
// A stalled result holds; the input register still takes one transaction,
// and req_stall rises only when both registers are full and rsp is stalled.
// ----------------------------------------------------------------------------
module stepper_axis_pulse_and_measure_top #(
   parameter int unsigned POSITION_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  stp_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output stp_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [stp_pkg::DATA_W-1:0]   csr_data
);
   import stp_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_data_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff;
   rsp_type           core_result;
   logic [DATA_W-1:0] home_ff;
   logic              out_ready;
   logic              advance;

   assign out_ready   = !out_valid_ff || !rsp_stall;
   assign advance     = s1_valid_ff && out_ready;
   assign req_stall   = s1_valid_ff && !out_ready;
   assign csr_ready   = 1'b1;
   assign s1_valid_in = (req_valid && !req_stall) || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         home_ff      <= HOME_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            home_ff <= csr_data;
         end
      end
   end

   // payload registers: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   stp_core #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (s1_data_ff),
      .home   (home_ff),
      .result (core_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled while a register was free");

   a_hold_blocked : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_ready) |=> (s1_valid_ff && $stable(s1_data_ff)))
      else $error("blocked transaction lost from input register");

   a_advance_fills_output : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced transaction produced no result");

endmodule

// ===== rtl/stp_core.sv =====
// ----------------------------------------------------------------------------
// stp_core
// Axis state and the next-state logic for one transaction: step toggle,
// limit stops, position count and reference edge measurement.
// ----------------------------------------------------------------------------
module stp_core #(
   parameter int unsigned POSITION_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  stp_pkg::req_type             item,
   input  logic [stp_pkg::DATA_W-1:0]   home,
   output stp_pkg::rsp_type             result
);
   import stp_pkg::*;

   localparam int unsigned PW = POSITION_WIDTH;
   localparam int unsigned EW = (PW > DATA_W) ? PW : DATA_W;

   logic          running_ff, running_in;
   logic          step_ff, step_in;
   logic          dir_ff, dir_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] total_ff, total_in;
   logic [PW-1:0] start_ff, start_in;
   logic [PW-1:0] end_ff, end_in;
   logic [PW-1:0] len_ff, len_in;
   logic          valid_ff, valid_in;
   logic          seen_ff, seen_in;
   logic          last_ref_ff, last_ref_in;

   logic [PW-1:0] pos_step;
   logic [EW-1:0] pos_ext, home_ext;

   assign pos_ext  = EW'(pos_ff);
   assign home_ext = EW'(home);

   always_comb begin
      if (dir_ff) begin
         pos_step = pos_ff + PW'(1);
      end else if (pos_ff != '0) begin
         pos_step = pos_ff - PW'(1);
      end else begin
         pos_step = pos_ff;
      end
   end

   always_comb begin
      running_in  = running_ff;
      step_in     = step_ff;
      dir_in      = dir_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      len_in      = len_ff;
      valid_in    = valid_ff;
      seen_in     = seen_ff;
      last_ref_in = last_ref_ff;
      unique case (item.action)
         ACT_TICK: begin
            priority if (running_ff && !dir_ff && item.limit_left) begin
               running_in = 1'b0;
               step_in    = 1'b0;
               pos_in     = PW'(home);
            end else if (running_ff && dir_ff && item.limit_right) begin
               running_in = 1'b0;
               step_in    = 1'b0;
               if (pos_ext >= home_ext) begin
                  total_in = PW'(pos_ext - home_ext);
               end
            end else if (!running_ff) begin
               step_in = 1'b0;
            end else begin
               step_in = !step_ff;
               // falling step edge: move one step and sample the reference
               if (step_ff) begin
                  pos_in      = pos_step;
                  last_ref_in = item.reference_level;
                  if (!last_ref_ff && item.reference_level) begin
                     start_in = pos_step;
                     seen_in  = 1'b1;
                     valid_in = 1'b0;
                  end else if (last_ref_ff && !item.reference_level && seen_ff) begin
                     end_in   = pos_step;
                     len_in   = (pos_step >= start_ff) ? pos_step - start_ff
                                                       : start_ff - pos_step;
                     valid_in = 1'b1;
                  end
               end
            end
         end
         ACT_START: begin
            running_in = 1'b1;
            dir_in     = item.move_dir;
         end
         ACT_STOP: begin
            running_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         step_ff     <= 1'b0;
         dir_ff      <= 1'b0;
         pos_ff      <= '0;
         total_ff    <= '0;
         start_ff    <= '0;
         end_ff      <= '0;
         len_ff      <= '0;
         valid_ff    <= 1'b0;
         seen_ff     <= 1'b0;
         last_ref_ff <= 1'b0;
      end else if (advance) begin
         running_ff  <= running_in;
         step_ff     <= step_in;
         dir_ff      <= dir_in;
         pos_ff      <= pos_in;
         total_ff    <= total_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         len_ff      <= len_in;
         valid_ff    <= valid_in;
         seen_ff     <= seen_in;
         last_ref_ff <= last_ref_in;
      end
   end

   always_comb begin
      result.step_out     = step_in;
      result.moving       = running_in;
      result.position     = DATA_W'(EW'(pos_in));
      result.total_length = DATA_W'(EW'(total_in));
      result.ref_start    = DATA_W'(EW'(start_in));
      result.ref_end      = DATA_W'(EW'(end_in));
      result.ref_length   = DATA_W'(EW'(len_in));
      result.ref_ok       = valid_in;
   end

endmodule
